### rtl/core/sphk_pkg.sv
// Package for the SPH kernel evaluator: types, constants and fixed-point helpers.
`timescale 1ns / 1ps
package sphk_pkg;

  localparam int FRAC_BITS_DEF = 16;

  // Unsigned Q.32 magnitude and signed Q.32 working value
  typedef logic [41:0]        uq_t;
  typedef logic signed [47:0] sq_t;

  typedef enum logic [1:0] {
    SHAPE_CUBIC   = 2'd0,
    SHAPE_QUINTIC = 2'd1,
    SHAPE_WC4     = 2'd2,
    SHAPE_WC6     = 2'd3
  } shape_t;

  localparam logic [1:0] ACT_BOTH   = 2'd0;
  localparam logic [1:0] ACT_WEIGHT = 2'd1;
  localparam logic [1:0] ACT_GRAD   = 2'd2;

  localparam logic REG_SHAPE = 1'b0;
  localparam logic REG_DIMS  = 1'b1;

  localparam uq_t Q_ONE  = 42'h1_0000_0000;
  localparam uq_t Q_HALF = 42'h0_8000_0000;
  localparam logic [83:0] RND_HALF = 84'h8000_0000;

  // Constant dividers: reciprocal floor(2^42 / D) and rounding offset D/2
  localparam uq_t D3   = 42'd3;
  localparam uq_t D27  = 42'd27;
  localparam uq_t D81  = 42'd81;
  localparam uq_t H3   = 42'd1;
  localparam uq_t H27  = 42'd13;
  localparam uq_t H81  = 42'd40;
  localparam uq_t R3   = 42'((64'd1 << 42) / 64'd3);
  localparam uq_t R27  = 42'((64'd1 << 42) / 64'd27);
  localparam uq_t R81  = 42'((64'd1 << 42) / 64'd81);

  // Normalization in Q.32: (p*K + q*128) / (q*256)
  localparam longint unsigned K1  = 64'd1 << 40;
  localparam longint unsigned KPI = 64'h51_7CC1_B727;
  localparam uq_t N_CU1 = 42'((64'd4 * K1 + 64'd3 * 128) / (64'd3 * 256));
  localparam uq_t N_CU2 = 42'((64'd40 * KPI + 64'd7 * 128) / (64'd7 * 256));
  localparam uq_t N_CU3 = 42'((64'd8 * KPI + 64'd1 * 128) / (64'd1 * 256));
  localparam uq_t N_QU1 = 42'((64'd243 * K1 + 64'd40 * 128) / (64'd40 * 256));
  localparam uq_t N_QU2 = 42'((64'd15309 * KPI + 64'd478 * 128) / (64'd478 * 256));
  localparam uq_t N_QU3 = 42'((64'd2187 * KPI + 64'd40 * 128) / (64'd40 * 256));
  localparam uq_t N_C41 = 42'((64'd3 * K1 + 64'd2 * 128) / (64'd2 * 256));
  localparam uq_t N_C42 = 42'((64'd9 * KPI + 64'd1 * 128) / (64'd1 * 256));
  localparam uq_t N_C43 = 42'((64'd495 * KPI + 64'd32 * 128) / (64'd32 * 256));
  localparam uq_t N_C61 = 42'((64'd55 * K1 + 64'd32 * 128) / (64'd32 * 256));
  localparam uq_t N_C62 = 42'((64'd78 * KPI + 64'd7 * 128) / (64'd7 * 256));
  localparam uq_t N_C63 = 42'((64'd1365 * KPI + 64'd64 * 128) / (64'd64 * 256));

  localparam sq_t OUT_MAX = 48'sh7FFF_FFFF_FFFF;
  localparam sq_t OUT_MIN = 48'sh8000_0000_0000;

  // Side information that rides along with each word
  typedef struct packed {
    logic [1:0]  act;
    shape_t      shp;
    logic        d1;
    logic [1:0]  didx;
    logic [31:0] h3;
    logic [31:0] h4;
  } side_t;

  // Partial products of a reciprocal division
  typedef struct packed {
    logic [62:0] ph;
    logic [62:0] pl;
    uq_t         x;
  } divp_t;

  // Q.32 product, rounded to nearest, ties up
  function automatic logic [47:0] mq(input uq_t a, input uq_t b);
    logic [83:0] p;
    p = ({42'd0, a} * {42'd0, b}) + RND_HALF;
    return p[79:32];
  endfunction

  function automatic uq_t mqn(input uq_t a, input uq_t b);
    logic [47:0] r;
    r = mq(a, b);
    return r[41:0];
  endfunction

  function automatic sq_t sx(input uq_t x);
    return $signed({6'd0, x});
  endfunction

  // Signed times unsigned, rounding on the magnitude
  function automatic sq_t mq_s(input sq_t x, input uq_t b);
    logic [47:0] m;
    logic [47:0] r;
    m = x[47] ? 48'(-x) : 48'(x);
    r = mq(m[41:0], b);
    return x[47] ? -$signed(r) : $signed(r);
  endfunction

  // Signed product clipped to the 48-bit output range
  function automatic sq_t mq_sat(input sq_t x, input uq_t b);
    logic [47:0] m;
    logic [47:0] r;
    m = x[47] ? 48'(-x) : 48'(x);
    r = mq(m[41:0], b);
    if (r[47]) return x[47] ? OUT_MIN : OUT_MAX;
    return x[47] ? -$signed(r) : $signed(r);
  endfunction

  function automatic divp_t div_pp(input uq_t x, input uq_t r);
    divp_t d;
    d.x  = x;
    d.ph = {42'd0, x[41:21]} * {21'd0, r};
    d.pl = {42'd0, x[20:0]} * {21'd0, r};
    return d;
  endfunction

  // Finish the quotient: estimate is exact or one low
  function automatic uq_t div_fin(input divp_t d, input uq_t dv);
    logic [83:0] s;
    uq_t q0;
    uq_t rem;
    s   = {d.ph, 21'd0} + {21'd0, d.pl};
    q0  = s[83:42];
    rem = d.x - 42'(q0 * dv);
    return (rem >= dv) ? q0 + 42'd1 : q0;
  endfunction

  function automatic uq_t norm_lookup(input shape_t shp, input logic [1:0] didx);
    uq_t n;
    case ({shp, didx})
      {SHAPE_CUBIC, 2'd0}:   n = N_CU1;
      {SHAPE_CUBIC, 2'd1}:   n = N_CU2;
      {SHAPE_QUINTIC, 2'd0}: n = N_QU1;
      {SHAPE_QUINTIC, 2'd1}: n = N_QU2;
      {SHAPE_QUINTIC, 2'd2}: n = N_QU3;
      {SHAPE_WC4, 2'd0}:     n = N_C41;
      {SHAPE_WC4, 2'd1}:     n = N_C42;
      {SHAPE_WC4, 2'd2}:     n = N_C43;
      {SHAPE_WC6, 2'd0}:     n = N_C61;
      {SHAPE_WC6, 2'd1}:     n = N_C62;
      {SHAPE_WC6, 2'd2}:     n = N_C63;
      default:               n = N_CU3;
    endcase
    return n;
  endfunction

  // Power of (1-u) that feeds the gradient of each Wendland shape
  function automatic logic [2:0] tlen(input side_t s);
    logic [2:0] m;
    case (s.shp)
      SHAPE_WC4: m = s.d1 ? 3'd4 : 3'd5;
      SHAPE_WC6: m = s.d1 ? 3'd6 : 3'd7;
      default:   m = 3'd5;
    endcase
    return m;
  endfunction

endpackage

### rtl/core/sph_kernel_eval.sv
// SPH smoothing kernel and gradient evaluator, twelve-stage pipeline.
//
// Usage: set kernel_shape (index 0) and dimensions (index 1) on the cfg
// channel while the block is idle; cfg_ready is always high. Each input word
// carries action, dist_norm (Q1.16), inv_h_cubed and inv_h_fourth (Q16.16);
// it is taken when item_valid is high and item_stall low. Each result word
// carries weight and gradient (signed Q32.16, saturating) and is taken when
// res_valid is high and res_stall low.
//
// One word enters every cycle while no result is held under res_stall. The
// depth is set by the chain of rounded products on (1-u): one multiplier
// level per stage, up to the eighth power, then the polynomial, a reciprocal
// divide by 3 over two stages, the norm and the h scale.
//
// Reset clears the valid bits and restores the cubic shape and three
// dimensions. While a result waits under res_stall the whole pipeline holds
// and item_stall is raised; nothing is dropped or repeated.
`timescale 1ns / 1ps
module sph_kernel_eval import sphk_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  logic [1:0]         action,
  input  logic [FRAC_BITS:0] dist_norm,
  input  logic [31:0]        inv_h_cubed,
  input  logic [31:0]        inv_h_fourth,
  output logic               res_valid,
  input  logic               res_stall,
  output logic signed [47:0] weight,
  output logic signed [47:0] gradient,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_index,
  input  logic [1:0]         cfg_data
);

  localparam uq_t LIM    = uq_t'(64'd1 << FRAC_BITS);
  localparam int  USHIFT = 32 - FRAC_BITS;

  shape_t     kernel_shape;
  logic [1:0] dimensions;
  logic       en;
  logic [11:1] vld;
  side_t      sd [1:11];
  side_t      side0;
  uq_t        dist_c, u0, three_u0;

  uq_t u_1, t1_1, a_1, b_1;
  logic lo_1;
  uq_t u_2, t1_2, a_2, b_2, u2_2, t2_2, aa_2, bb_2;
  logic lo_2;
  sq_t cg_2;
  uq_t u_3, u2_3, u3_3, t1_3, t2_3, t4_3, a_3, b_3, a4_3, b4_3, cw1_3, cw2_3;
  logic lo_3;
  sq_t cg_3;
  uq_t u_4, t1_4, t4_4, tm_4, a4_4, b4_4, a5_4, b5_4, pw_4, pg_4;
  sq_t cw_4, cg_4;
  uq_t pw_next, pg_next;
  uq_t u_5, t1_5, t4_5, t5_5, tm_5, pw_5, pg_5;
  divp_t da_5, db_5, dc_5, dd_5;
  sq_t cw_5, cg_5;
  uq_t u_6, t1_6, tm_6, pw_6, pg_6;
  sq_t ew_6, eg_6, qw_next, qg_next;
  uq_t tn_7, tu_7, pw_7, pg_7;
  sq_t ew_7, eg_7;
  uq_t wp_8, gp_8;
  sq_t ew_8, eg_8;
  uq_t wp_9, gp_9;
  divp_t dw_9, dg_9;
  sq_t ew_9, eg_9;
  sq_t w_10, g_10, w_next, g_next;
  sq_t wn_11, gn_11;

  // Pipeline moves unless a finished word is held by the receiver
  assign en         = !(res_valid && res_stall);
  assign item_stall = !en;
  assign cfg_ready  = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      kernel_shape <= SHAPE_CUBIC;
      dimensions   <= 2'd3;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_SHAPE: kernel_shape <= shape_t'(cfg_data);
        REG_DIMS:  dimensions   <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp and widen u, capture side info
  always_comb begin
    dist_c      = (uq_t'(dist_norm) > LIM) ? LIM : uq_t'(dist_norm);
    u0          = dist_c << USHIFT;
    three_u0    = u0 * 42'd3;
    side0.act   = action;
    side0.shp   = kernel_shape;
    side0.d1    = (dimensions == 2'd1);
    side0.didx  = (dimensions == 2'd0) ? 2'd2 : dimensions - 2'd1;
    side0.h3    = inv_h_cubed;
    side0.h4    = inv_h_fourth;
  end

  // Valid bits and side info advance with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      res_valid <= 1'b0;
    end else if (en) begin
      vld       <= {vld[10:1], item_valid};
      res_valid <= vld[11];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= side0;
      for (int k = 2; k <= 11; k++) sd[k] <= sd[k-1];
    end
  end

  // Wendland polynomials for the shape in stage 3
  always_comb begin
    pw_next = '0;
    pg_next = '0;
    case (sd[3].shp)
      SHAPE_WC4: begin
        if (sd[3].d1) begin
          pw_next = Q_ONE + u_3 * 42'd5 + u2_3 * 42'd8;
          pg_next = Q_ONE * 42'd14 + u_3 * 42'd56;
        end else begin
          pw_next = Q_ONE * 42'd3 + u_3 * 42'd18 + u2_3 * 42'd35;
          pg_next = u_3 * 42'd280 + Q_ONE * 42'd56;
        end
      end
      SHAPE_WC6: begin
        if (sd[3].d1) begin
          pw_next = Q_ONE + u_3 * 42'd7 + u2_3 * 42'd19 + u3_3 * 42'd21;
          pg_next = Q_ONE * 42'd3 + u_3 * 42'd18 + u2_3 * 42'd35;
        end else begin
          pw_next = Q_ONE + u_3 * 42'd8 + u2_3 * 42'd25 + u3_3 * 42'd32;
          pg_next = Q_ONE + u_3 * 42'd7 + u2_3 * 42'd16;
        end
      end
      default: ;
    endcase
  end

  // Quintic sums for the early result
  always_comb begin
    qg_next = sx(div_fin(da_5, D27)) - sx(div_fin(db_5, D27)) - sx(t4_5 * 42'd5);
    qw_next = sx(t5_5) - sx(div_fin(dc_5, D81)) + sx(div_fin(dd_5, D81));
  end

  // Final pick of weight and gradient per shape
  always_comb begin
    case (sd[9].shp)
      SHAPE_WC4: begin
        if (sd[9].d1) begin
          w_next = sx(wp_9);
          g_next = -sx(gp_9);
        end else begin
          w_next = sx(div_fin(dw_9, D3));
          g_next = -sx(div_fin(dg_9, D3));
        end
      end
      SHAPE_WC6: begin
        w_next = sx(wp_9);
        g_next = sd[9].d1 ? -sx(gp_9 * 42'd6) : -sx(gp_9 * 42'd22);
      end
      default: begin
        w_next = ew_9;
        g_next = eg_9;
      end
    endcase
  end

  // Datapath stages
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1: u, 1-u, and the quintic offsets
      u_1  <= u0;
      t1_1 <= Q_ONE - u0;
      a_1  <= (three_u0 < (Q_ONE << 1)) ? (Q_ONE << 1) - three_u0 : '0;
      b_1  <= (three_u0 < Q_ONE) ? Q_ONE - three_u0 : '0;
      lo_1 <= (u0 < Q_HALF);

      // stage 2: squares, cubic inner gradient
      u_2  <= u_1;
      t1_2 <= t1_1;
      a_2  <= a_1;
      b_2  <= b_1;
      lo_2 <= lo_1;
      u2_2 <= mqn(u_1, u_1);
      t2_2 <= mqn(t1_1, t1_1);
      aa_2 <= mqn(a_1, a_1);
      bb_2 <= mqn(b_1, b_1);
      cg_2 <= mq_s(sx(u_1 * 42'd18) - sx(Q_ONE * 42'd12), u_1);

      // stage 3: cubes and fourth powers
      u_3   <= u_2;
      u2_3  <= u2_2;
      u3_3  <= mqn(u2_2, u_2);
      t1_3  <= t1_2;
      t2_3  <= t2_2;
      t4_3  <= mqn(t2_2, t2_2);
      a_3   <= a_2;
      b_3   <= b_2;
      a4_3  <= mqn(aa_2, aa_2);
      b4_3  <= mqn(bb_2, bb_2);
      cw1_3 <= mqn(t1_2, u2_2);
      cw2_3 <= mqn(t2_2, t1_2);
      lo_3  <= lo_2;
      cg_3  <= cg_2;

      // stage 4: fifth powers, cubic result, polynomials
      u_4  <= u_3;
      t1_4 <= t1_3;
      t4_4 <= t4_3;
      tm_4 <= (tlen(sd[3]) > 3'd4) ? mqn(t4_3, t1_3) : t4_3;
      a4_4 <= a4_3;
      b4_4 <= b4_3;
      a5_4 <= mqn(a4_3, a_3);
      b5_4 <= mqn(b4_3, b_3);
      cw_4 <= lo_3 ? sx(Q_ONE) - sx(cw1_3 * 42'd6) : sx(cw2_3 * 42'd2);
      cg_4 <= lo_3 ? cg_3 : -sx(t2_3 * 42'd6);
      pw_4 <= pw_next;
      pg_4 <= pg_next;

      // stage 5: power chain, quintic divide partial products
      u_5  <= u_4;
      t1_5 <= t1_4;
      t4_5 <= t4_4;
      t5_5 <= tm_4;
      tm_5 <= (tlen(sd[4]) > 3'd5) ? mqn(tm_4, t1_4) : tm_4;
      da_5 <= div_pp(a4_4 * 42'd10 + H27, R27);
      db_5 <= div_pp(b4_4 * 42'd25 + H27, R27);
      dc_5 <= div_pp(a5_4 * 42'd2 + H81, R81);
      dd_5 <= div_pp(b5_4 * 42'd5 + H81, R81);
      cw_5 <= cw_4;
      cg_5 <= cg_4;
      pw_5 <= pw_4;
      pg_5 <= pg_4;

      // stage 6: power chain, early result
      u_6  <= u_5;
      t1_6 <= t1_5;
      tm_6 <= (tlen(sd[5]) > 3'd6) ? mqn(tm_5, t1_5) : tm_5;
      ew_6 <= (sd[5].shp == SHAPE_CUBIC) ? cw_5 : qw_next;
      eg_6 <= (sd[5].shp == SHAPE_CUBIC) ? cg_5 : qg_next;
      pw_6 <= pw_5;
      pg_6 <= pg_5;

      // stage 7: next power and times u
      tn_7 <= mqn(tm_6, t1_6);
      tu_7 <= mqn(tm_6, u_6);
      pw_7 <= pw_6;
      pg_7 <= pg_6;
      ew_7 <= ew_6;
      eg_7 <= eg_6;

      // stage 8: polynomial products
      wp_8 <= mqn(tn_7, pw_7);
      gp_8 <= mqn(tu_7, pg_7);
      ew_8 <= ew_7;
      eg_8 <= eg_7;

      // stage 9: divide by three, partial products
      wp_9 <= wp_8;
      gp_9 <= gp_8;
      dw_9 <= div_pp(wp_8 + H3, R3);
      dg_9 <= div_pp(gp_8 + H3, R3);
      ew_9 <= ew_8;
      eg_9 <= eg_8;

      // stage 10: final kernel values
      w_10 <= w_next;
      g_10 <= g_next;

      // stage 11: normalization
      wn_11 <= mq_s(w_10, norm_lookup(sd[10].shp, sd[10].didx));
      gn_11 <= mq_s(g_10, norm_lookup(sd[10].shp, sd[10].didx));

      // stage 12: h scaling, saturation, drop unrequested results
      weight   <= (sd[11].act != ACT_GRAD) ? mq_sat(wn_11, uq_t'(sd[11].h3)) : '0;
      gradient <= (sd[11].act != ACT_WEIGHT) ? mq_sat(gn_11, uq_t'(sd[11].h4)) : '0;
    end
  end

  // A word leaving stage 11 shows up as a result
  a_valid_travel: assert property (@(posedge clk) disable iff (rst)
    (en && vld[11]) |=> res_valid)
    else $error("result valid lost at output stage");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid set after reset");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> res_valid)
    else $error("input stalled with no result waiting");

  a_cubic_range: assert property (@(posedge clk) disable iff (rst)
    (vld[4] && sd[4].shp == SHAPE_CUBIC) |-> (cw_4 >= 0 && cw_4 <= sx(Q_ONE)))
    else $error("cubic weight out of range");

endmodule

### dv/tb_sph_kernel_eval.sv
// Self-checking testbench for the SPH kernel and gradient evaluator.
`timescale 1ns / 1ps
module tb_sph_kernel_eval;
  import sphk_pkg::*;

  localparam longint QONE = 64'sd1 <<< 32;
  localparam longint unsigned INV_PI_Q40 = 64'h51_7CC1_B727;
  localparam longint SAT_HI = (64'sd1 <<< 47) - 1;
  localparam longint SAT_LO = -(64'sd1 <<< 47);
  localparam int HOLD_CYCLES = 200;
  localparam int WATCH_LIMIT = 5000;
  localparam int PHASE_ITEMS = 86;
  localparam int DRAIN_CYCLES = 20;

  typedef struct {
    logic signed [47:0] w;
    logic signed [47:0] g;
  } kern_res_t;

  typedef struct {
    logic [1:0]         act;
    logic [16:0]        dnorm;
    logic [31:0]        h3;
    logic [31:0]        h4;
    bit                 typed;
    logic signed [47:0] w;
    logic signed [47:0] g;
  } dir_row_t;

  logic clk;
  logic rst;
  logic item_valid;
  logic item_stall;
  logic [1:0] action;
  logic [16:0] dist_norm;
  logic [31:0] inv_h_cubed;
  logic [31:0] inv_h_fourth;
  logic res_valid;
  logic res_stall;
  logic signed [47:0] weight;
  logic signed [47:0] gradient;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [1:0] cfg_data;

  shape_t cur_shape;
  logic [1:0] cur_dims;
  kern_res_t kern_expected[$];
  int fail_count;
  int idle_cycles;
  bit quiet;
  bit hold_req;

  sph_kernel_eval dut (.*);

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Rounded Q.32 product, ties away from zero, clipped to int64
  function automatic longint qmul(longint a, longint b);
    logic [127:0] p;
    longint unsigned ma, mb;
    bit neg;
    neg = (a < 0) != (b < 0);
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    p = ({64'd0, ma} * {64'd0, mb} + 128'h8000_0000) >> 32;
    if (p > 128'h7FFF_FFFF_FFFF_FFFF) p = 128'h7FFF_FFFF_FFFF_FFFF;
    return neg ? -longint'(p[63:0]) : longint'(p[63:0]);
  endfunction

  function automatic longint qdiv(longint x, longint unsigned d);
    longint unsigned r;
    r = (((x < 0) ? -x : x) + d / 2) / d;
    return (x < 0) ? -longint'(r) : longint'(r);
  endfunction

  function automatic logic signed [47:0] clip48(longint v);
    if (v > SAT_HI) v = SAT_HI;
    if (v < SAT_LO) v = SAT_LO;
    return v[47:0];
  endfunction

  // Weight and gradient of one word under the current shape and dimensions
  function automatic kern_res_t kernel_eval(logic [1:0] act, logic [16:0] dnorm,
                                            logic [31:0] h3, logic [31:0] h4);
    int unsigned nums[4][3] = '{'{4, 40, 8}, '{243, 15309, 2187},
                                '{3, 9, 495}, '{55, 78, 1365}};
    int unsigned dens[4][3] = '{'{3, 7, 1}, '{40, 478, 40},
                                '{2, 1, 32}, '{32, 7, 64}};
    longint u, u2, u3, t1, t2, t4, t5, t6, t7, t8, w, g, nrm, a, a2, a4, b, b2, b4;
    longint unsigned ud, kk;
    int dim;
    kern_res_t r;
    ud = (dnorm > 17'd65536) ? 65536 : dnorm;
    u = longint'(ud << 16);
    dim = (cur_dims == 2'd0) ? 3 : cur_dims;
    u2 = qmul(u, u);
    u3 = qmul(u2, u);
    t1 = QONE - u;
    t2 = qmul(t1, t1);
    t4 = qmul(t2, t2);
    t5 = qmul(t4, t1);
    t6 = qmul(t5, t1);
    t7 = qmul(t6, t1);
    t8 = qmul(t7, t1);
    case (cur_shape)
      SHAPE_CUBIC: begin
        if (u < QONE / 2) begin
          g = qmul(u, 18 * u - 12 * QONE);
          w = QONE + 6 * qmul(u - QONE, u2);
        end else begin
          g = -6 * t2;
          w = 2 * qmul(t2, t1);
        end
      end
      SHAPE_QUINTIC: begin
        g = -5 * t4;
        w = t5;
        if (3 * u < 2 * QONE) begin
          a = 2 * QONE - 3 * u;
          a2 = qmul(a, a);
          a4 = qmul(a2, a2);
          g += qdiv(10 * a4, 27);
          w -= qdiv(2 * qmul(a4, a), 81);
        end
        if (3 * u < QONE) begin
          b = QONE - 3 * u;
          b2 = qmul(b, b);
          b4 = qmul(b2, b2);
          g -= qdiv(25 * b4, 27);
          w += qdiv(5 * qmul(b4, b), 81);
        end
      end
      SHAPE_WC4: begin
        if (dim == 1) begin
          g = -qmul(qmul(t4, u), 14 * QONE + 56 * u);
          w = qmul(t5, QONE + 5 * u + 8 * u2);
        end else begin
          g = -qdiv(qmul(qmul(t5, u), 280 * u + 56 * QONE), 3);
          w = qdiv(qmul(t6, 3 * QONE + 18 * u + 35 * u2), 3);
        end
      end
      default: begin
        if (dim == 1) begin
          g = -6 * qmul(qmul(t6, u), 3 * QONE + 18 * u + 35 * u2);
          w = qmul(t7, QONE + 7 * u + 19 * u2 + 21 * u3);
        end else begin
          g = -22 * qmul(qmul(t7, u), QONE + 7 * u + 16 * u2);
          w = qmul(t8, QONE + 8 * u + 25 * u2 + 32 * u3);
        end
      end
    endcase
    // Normalization carries 1/pi except for one dimension
    kk = (dim == 1) ? (64'd1 << 40) : INV_PI_Q40;
    nrm = longint'((longint'(nums[cur_shape][dim - 1]) * kk
                    + longint'(dens[cur_shape][dim - 1]) * 128)
                   / (longint'(dens[cur_shape][dim - 1]) * 256));
    r.w = (act != ACT_GRAD) ? clip48(qmul(qmul(w, nrm), longint'(h3))) : '0;
    r.g = (act != ACT_WEIGHT) ? clip48(qmul(qmul(g, nrm), longint'(h4))) : '0;
    return r;
  endfunction

  task automatic write_reg(logic idx, logic [1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_SHAPE) cur_shape = shape_t'(val);
    else cur_dims = val;
    @(posedge clk);
  endtask

  // Offer one word and hold it until taken
  task automatic send_word(logic [1:0] act, logic [16:0] dnorm, logic [31:0] h3,
                           logic [31:0] h4, bit typed, logic signed [47:0] tw,
                           logic signed [47:0] tg);
    kern_res_t r;
    item_valid <= 1'b1;
    action <= act;
    dist_norm <= dnorm;
    inv_h_cubed <= h3;
    inv_h_fourth <= h4;
    @(posedge clk);
    while (item_stall) @(posedge clk);
    if (typed) begin
      r.w = tw;
      r.g = tg;
    end else begin
      r = kernel_eval(act, dnorm, h3, h4);
    end
    kern_expected.push_back(r);
    if (!quiet && $urandom_range(0, 99) < 6) begin
      item_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain;
    item_valid <= 1'b0;
    @(posedge clk);
    while (kern_expected.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  function automatic logic [16:0] pick_dist;
    logic [16:0] marks[5] = '{17'd0, 17'd21845, 17'd32768, 17'd43690, 17'd65536};
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 60) return 17'($urandom_range(0, 65536));
    if (sel < 70) return 17'($urandom_range(65537, 131071));
    return 17'(int'(marks[$urandom_range(0, 4)]) + $urandom_range(0, 8)) - 17'd4;
  endfunction

  function automatic logic [31:0] pick_scale;
    int sel;
    sel = $urandom_range(0, 99);
    if (sel < 5) return 32'd0;
    if (sel < 10) return 32'hFFFF_FFFF;
    return $urandom();
  endfunction

  // Stimulus: directed table, then random words over all settings
  initial begin
    dir_row_t rows[20] = '{
      '{ACT_BOTH,   17'd0,      32'h0001_0000, 32'h0001_0000, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd0,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 48'sd0, 48'sd0},
      '{ACT_WEIGHT, 17'd0,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 48'sd0, 48'sd0},
      '{ACT_GRAD,   17'd16384,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 48'sd0, 48'sd0},
      '{2'd3,       17'd16384,  32'h0002_0000, 32'h0003_0000, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd32767,  32'h0001_0000, 32'h0001_0000, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd32768,  32'h0001_0000, 32'h0001_0000, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd21845,  32'h0001_0000, 32'h0001_0000, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd21846,  32'h0001_0000, 32'h0001_0000, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd43690,  32'h0001_0000, 32'h0001_0000, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd43691,  32'h0001_0000, 32'h0001_0000, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd65535,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd65536,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd65537,  32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 48'sd0, 48'sd0},
      '{2'd3,       17'd131071, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd1000,   32'd0,         32'd0,         1, 48'sd0, 48'sd0},
      '{ACT_GRAD,   17'd0,      32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 48'sd0, 48'sd0},
      '{ACT_WEIGHT, 17'd50000,  32'h8000_0000, 32'h8000_0000, 0, 48'sd0, 48'sd0},
      '{ACT_GRAD,   17'd50000,  32'h5555_5555, 32'hAAAA_AAAA, 0, 48'sd0, 48'sd0},
      '{ACT_BOTH,   17'd10000,  32'hAAAA_AAAA, 32'h5555_5555, 0, 48'sd0, 48'sd0}
    };
    int phase;
    rst = 1'b1;
    item_valid = 1'b0;
    action = '0;
    dist_norm = '0;
    inv_h_cubed = '0;
    inv_h_fourth = '0;
    cfg_valid = 1'b0;
    cfg_index = 1'b0;
    cfg_data = '0;
    quiet = 1'b0;
    hold_req = 1'b0;
    fail_count = 0;
    cur_shape = SHAPE_CUBIC;
    cur_dims = 2'd3;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed words under the reset settings
    foreach (rows[i])
      send_word(rows[i].act, rows[i].dnorm, rows[i].h3, rows[i].h4,
                rows[i].typed, rows[i].w, rows[i].g);
    drain();

    // Every shape against one, two, three and zero dimensions
    phase = 0;
    for (int s = 0; s < 4; s++) begin
      for (int d = 0; d < 4; d++) begin
        write_reg(REG_SHAPE, 2'(s));
        write_reg(REG_DIMS, (d == 3) ? 2'd0 : 2'(d + 1));
        quiet = (phase == 3 || phase == 4);
        if (phase == 6) hold_req = 1'b1;
        for (int n = 0; n < PHASE_ITEMS; n++) begin
          if (phase == 9 && n == 40) drain();
          send_word(2'($urandom_range(0, 3)), pick_dist(), pick_scale(), pick_scale(),
                    0, 48'sd0, 48'sd0);
        end
        drain();
        phase++;
      end
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && kern_expected.size() == 0) $display("Verification passed");
    else $display("Verification failed");
    $finish;
  end

  // Drive the result stall: random, quiet stretches, one long hold
  initial begin
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 0;
    res_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_left = HOLD_CYCLES;
        hold_done = 1;
      end
      if (hold_left > 0) begin
        hold_left--;
        res_stall <= 1'b1;
      end else begin
        res_stall <= !rst && !quiet && ($urandom_range(0, 99) < 6);
      end
    end
  end

  // Check each result word against the oldest expectation
  always @(posedge clk) begin
    kern_res_t e;
    if (!rst && res_valid && !res_stall) begin
      if (kern_expected.size() == 0) begin
        $error("result word with no expectation waiting");
        fail_count++;
      end else begin
        e = kern_expected.pop_front();
        if (weight !== e.w) begin
          $error("weight expected %0d actual %0d", e.w, weight);
          fail_count++;
        end
        if (gradient !== e.g) begin
          $error("gradient expected %0d actual %0d", e.g, gradient);
          fail_count++;
        end
      end
    end
  end

  // Stop the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (item_valid && !item_stall) || (res_valid && !res_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### sph_kernel_eval.f
rtl/core/sphk_pkg.sv
rtl/core/sph_kernel_eval.sv
dv/tb_sph_kernel_eval.sv
